@@ hdl/smr_pkg.sv @@
// Shared types and constants for the softmax row block.
// No dependencies; imported by every module under hdl.
package smr_pkg;

   localparam int MAX_LEN = 64;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int SUM_W   = 23;
   localparam int EXP_W   = 17;
   localparam int REM_W   = 24;
   localparam int QUO_W   = 16;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [SUM_W-1:0] SUM_MIN = 23'd65536;
   localparam logic [15:0] PROB_SAT = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0]      probability;
      logic [IDX_W-1:0] position;
      logic             row_end;
      logic             overflow;
   } rsp_type;

   // Row descriptor handed from the load side to the compute side
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [15:0]      row_max;
      logic             overflow;
   } desc_type;

   // 65536 * 2^(-k/16), k = 0..16
   function automatic logic [16:0] pow2_frac(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/smr_queue.sv @@
// Two-entry descriptor queue between load front and compute back.
// Depends on smr_pkg.
module smr_queue import smr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type pop_data,
   output logic     empty
);

   desc_type   entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;

   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop  ? ~rptr_ff : rptr_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (push) entry_ff[wptr_ff] <= push_data;
   end

endmodule

@@ hdl/smr_front.sv @@
// Load side: stores row samples, tracks max, count and overflow.
// Depends on smr_pkg; the row memory is read by smr_back.
module smr_front import smr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  req_type          req,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [15:0]      rd_data,
   output logic             push,
   output desc_type         push_data
);

   logic [15:0]      row_mem [MAX_LEN];
   logic [15:0]      rd_data_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      max_ff, max_in;
   logic             ovf_ff, ovf_in;
   logic             store;

   assign store   = accept && (count_ff < CNT_W'(MAX_LEN));
   assign rd_data = rd_data_ff;

   // Next row state; end of row hands a descriptor over and rearms
   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      ovf_in   = ovf_ff;
      if (store) begin
         count_in = count_ff + 1'b1;
         if (req.sample > $signed(max_ff)) max_in = req.sample;
      end else if (accept) begin
         ovf_in = 1'b1;
      end
      push           = accept && req.last;
      push_data      = '{count: count_in, row_max: max_in, overflow: ovf_in};
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff <= '0;
         max_ff   <= 16'h8000;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         ovf_ff   <= ovf_in;
      end
      if (store) row_mem[count_ff[IDX_W-1:0]] <= req.sample;
      rd_data_ff <= row_mem[rd_addr];
   end

endmodule

@@ hdl/smr_back.sv @@
// Compute side: exponent pass into the exp memory, then per-element divide.
// Depends on smr_pkg; reads the row memory inside smr_front.
module smr_back import smr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  desc_type         q_data,
   output logic             q_pop,
   output logic             active,
   output logic [IDX_W-1:0] rd_addr,
   input  logic [15:0]      rd_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   typedef enum logic [2:0] {S_IDLE, S_EXP, S_DIV_ADDR, S_DIV_LOAD, S_DIV_RUN} state_type;

   state_type        state_ff;
   desc_type         desc_ff;
   logic [CNT_W-1:0] iss_ff, wr_ff, k_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             p1_ff, p2_ff, p3_ff;
   logic [20:0]      u_ff;
   logic [16:0]      t_ff;
   logic [23:0]      dr_ff;
   logic [4:0]       n_ff;
   logic [EXP_W-1:0] exp_mem [MAX_LEN];
   logic [EXP_W-1:0] exp_rd_ff;
   logic [REM_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic             sat_ff;
   logic [3:0]       step_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             issue;
   logic [16:0]      diff;
   logic [32:0]      prod;
   logic [3:0]       fi;
   logic [11:0]      fr;
   logic [11:0]      tdelta;
   logic [16:0]      m;
   logic [EXP_W-1:0] e;
   logic [REM_W-1:0] rem2;
   logic             ge;
   logic [QUO_W-1:0] quo_in;

   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   assign active    = (state_ff != S_IDLE);
   assign issue     = (state_ff == S_EXP) && (iss_ff < desc_ff.count);
   assign rd_addr   = iss_ff[IDX_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Exponent datapath: difference and log2(e) scale, table lerp, shift
   always_comb begin
      diff   = {desc_ff.row_max[15], desc_ff.row_max} - {rd_data[15], rd_data};
      prod   = 33'(diff[15:0]) * 33'(LOG2E_Q16);
      fi     = u_ff[15:12];
      fr     = u_ff[11:0];
      tdelta = 12'(pow2_frac({1'b0, fi}) - pow2_frac({1'b0, fi} + 5'd1));
      m      = t_ff - 17'(dr_ff >> 12);
      e      = (n_ff > 5'd16) ? '0 : (m >> n_ff);
   end

   // Restoring divide step, one quotient bit per cycle
   always_comb begin
      rem2   = rem_ff << 1;
      ge     = rem2 >= REM_W'(sum_ff);
      quo_in = {quo_ff[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         p3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_ff        <= issue;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  desc_ff  <= q_data;
                  iss_ff   <= '0;
                  wr_ff    <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_EXP;
               end
            end
            S_EXP: begin
               if (issue) iss_ff <= iss_ff + 1'b1;
               if (p3_ff) begin
                  wr_ff  <= wr_ff + 1'b1;
                  sum_ff <= sum_ff + SUM_W'(e);
                  if (wr_ff + 1'b1 == desc_ff.count) begin
                     k_ff     <= '0;
                     state_ff <= S_DIV_ADDR;
                  end
               end
            end
            S_DIV_ADDR: state_ff <= S_DIV_LOAD;
            S_DIV_LOAD: begin
               rem_ff   <= REM_W'(exp_rd_ff);
               sat_ff   <= SUM_W'(exp_rd_ff) >= sum_ff;
               step_ff  <= '0;
               state_ff <= S_DIV_RUN;
            end
            S_DIV_RUN: begin
               rem_ff  <= ge ? rem2 - REM_W'(sum_ff) : rem2;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd15) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{probability: sat_ff ? PROB_SAT : quo_in,
                                    position: k_ff[IDX_W-1:0],
                                    row_end: (k_ff + 1'b1 == desc_ff.count),
                                    overflow: desc_ff.overflow};
                  k_ff         <= k_ff + 1'b1;
                  state_ff     <= (k_ff + 1'b1 == desc_ff.count) ? S_IDLE : S_DIV_ADDR;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      // Exponent pipeline registers
      u_ff  <= prod[32:12];
      t_ff  <= pow2_frac({1'b0, fi});
      dr_ff <= 24'(tdelta) * 24'(fr);
      n_ff  <= u_ff[20:16];
      // Exp memory: written in the exponent pass, read in the divide pass
      if (state_ff == S_EXP && p3_ff) exp_mem[wr_ff[IDX_W-1:0]] <= e;
      exp_rd_ff <= exp_mem[k_ff[IDX_W-1:0]];
   end

`ifndef SYNTH
   // The row's last result returns the sequencer to idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.row_end |-> state_ff == S_IDLE)
      else $error("row end without return to idle");
   // The maximum element alone contributes 1.0, so the divisor is never below it
   a_sum_min: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_LOAD |-> sum_ff >= SUM_MIN)
      else $error("exp sum below 1.0");
   // Results are separated by a full divide
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back results");
   // No new row is taken while one is in flight
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_EXP)
      else $error("descriptor pop without starting exp pass");
`endif

endmodule

@@ hdl/softmax_row_top.sv @@
// Top level of the softmax row block.
// Depends on smr_pkg, smr_front, smr_queue and smr_back.
//
// Usage: drive req_data (sample, last) and raise start; a transaction is
// taken at a clock edge where start is high and busy is low. Samples are
// stored one per cycle while busy stays low. The transaction carrying last
// closes the row; busy then rises until every result of the row is out.
// Samples beyond 64 in a row are dropped and overflow is flagged on all
// of that row's results.
// Results: rsp_valid pulses for one cycle per element, in row order, with
// rsp_data (probability, position, row_end, overflow). The receiver cannot
// stall; each result must be taken in its cycle.
// Flow: the row is handed over through the queue, then the exponent pass
// streams one element per cycle through the row memory port and the exp
// pipeline (u_ff, then t_ff, dr_ff and n_ff) into the exp memory. Each result
// then passes the S_DIV_ADDR and S_DIV_LOAD states and the 16-step restoring
// divider; a new result starts only after the previous one is out.
// Reset: synchronous, clears row state, queue and sequencer; memory content
// is not cleared and needs no clearing pass.
module softmax_row_top import smr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic             accept;
   logic             push, pop, q_empty, back_active;
   desc_type         push_data, pop_data;
   logic [IDX_W-1:0] rd_addr;
   logic [15:0]      rd_data;

   // Hold off new rows while one is queued or being computed
   assign busy   = !q_empty || back_active;
   assign accept = start && !busy;

   smr_front u_front (
      .clock, .reset, .accept, .req(req_data), .rd_addr, .rd_data,
      .push, .push_data
   );

   smr_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .empty(q_empty)
   );

   smr_back u_back (
      .clock, .reset, .q_empty, .q_data(pop_data), .q_pop(pop),
      .active(back_active), .rd_addr, .rd_data, .rsp_valid, .rsp_data
   );

endmodule
